// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the rhs_ctrl sequencer. The checks are
// compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/rhs_pkg.sv =====
// ---------------------------------------------------------------------------
// rhs_pkg
// Shared constants, request codes and controller/datapath interface types of
// the resource hazard scoreboard.
// ---------------------------------------------------------------------------
package rhs_pkg;

  // default sizing
  localparam int ENTRIES_DEF      = 64;
  localparam int MAX_REPORTED_DEF = 16;

  // stream payload widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;

  // field widths
  localparam int RES_W    = 16;
  localparam int FRAME_W  = 32;
  localparam int STAGE_W  = 8;
  localparam int MATCH_W  = 5;
  localparam int REMOV_W  = 7;
  localparam int TOTAL_W  = 32;
  localparam int WINDOW_W = 8;

  // config port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_BARRIER_EN = 1'b0;
  localparam logic REG_FRAME_WIN  = 1'b1;
  localparam logic [WINDOW_W-1:0] FRAME_WIN_RST = 8'd3;

  // request codes
  localparam logic [1:0] REQ_ACCESS    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE   = 2'd1;
  localparam logic [1:0] REQ_CLEAR     = 2'd2;
  localparam logic [1:0] REQ_RESET_CNT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request, clear accumulators
    logic scan;    // read the next table entry
    logic commit;  // update table/counters, present the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // the entry being read is the last one
    logic out_free;   // output register can take a result
  } stat_t;

endpackage

// ===== src/resource_hazard_scoreboard_top.sv =====
// ---------------------------------------------------------------------------
// resource_hazard_scoreboard_top
// Read/write hazard scoreboard over a table of recent resource accesses.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream; in_tuser carries the request kind
//   (access, frame advance, clear table, zero counters). Every request gives
//   exactly one result on the out_ stream with the hazard/barrier flags,
//   match and removal counts and both running totals.
//   Access and frame-advance requests scan the table one entry per cycle
//   through the entry memory read port. Clear-table and counter-zero requests
//   skip the scan. One request is in work at a time. Configuration is written
//   through the cfg_ APB port; the user must write it only while idle, and the
//   block itself has no check for this.
//   The result sits in an output register; the next request is accepted
//   while it waits. A stalled receiver holds the finished request in its
//   final step until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table at once, zeroes both
//   counters and restores barrier enable = 1, frame window = 3.
// ---------------------------------------------------------------------------
module resource_hazard_scoreboard_top #(
  parameter int ENTRIES      = rhs_pkg::ENTRIES_DEF,
  parameter int MAX_REPORTED = rhs_pkg::MAX_REPORTED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] resource_id, [16] is_read, [17] is_write, [49:18] frame,
  // [57:50] stages, [63:58] zero
  input  logic [rhs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [rhs_pkg::IN_USER_W-1:0]   in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hazard, [1] barrier, [9:2] barrier_stages, [14:10] match_count,
  // [15] overflow, [22:16] removed_count, [54:23] hazards_total,
  // [86:55] barriers_total, [87] zero
  output logic [rhs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rhs_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [rhs_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [rhs_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import rhs_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic                barrier_enable;
  logic [WINDOW_W-1:0] frame_window;

  rhs_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .barrier_enable (barrier_enable),
    .frame_window   (frame_window)
  );

  rhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhs_dp #(
    .ENTRIES      (ENTRIES),
    .MAX_REPORTED (MAX_REPORTED)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .barrier_enable (barrier_enable),
    .frame_window   (frame_window),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

// ===== src/rhs_cfg.sv =====
// ---------------------------------------------------------------------------
// rhs_cfg
// APB-style register file: barrier enable and frame window.
// ---------------------------------------------------------------------------
module rhs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rhs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rhs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rhs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output logic                        barrier_enable,
  output logic [rhs_pkg::WINDOW_W-1:0] frame_window
);
  import rhs_pkg::*;

  logic                barrier_en_r, barrier_en_nxt;
  logic [WINDOW_W-1:0] frame_win_r, frame_win_nxt;
  logic                wr_en;
  logic                reg_sel;

  // word select; the byte-lane bits of the address are not decoded
  assign reg_sel = cfg_paddr[2];
  assign wr_en   = cfg_psel & cfg_penable & cfg_pwrite;

  // register write
  always_comb begin
    barrier_en_nxt = barrier_en_r;
    frame_win_nxt  = frame_win_r;
    if (wr_en) begin
      case (reg_sel)
        REG_BARRIER_EN: barrier_en_nxt = cfg_pwdata[0];
        REG_FRAME_WIN:  frame_win_nxt  = cfg_pwdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      barrier_en_r <= 1'b1;
      frame_win_r  <= FRAME_WIN_RST;
    end else begin
      barrier_en_r <= barrier_en_nxt;
      frame_win_r  <= frame_win_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_BARRIER_EN: cfg_prdata = {{(CFG_DW-1){1'b0}}, barrier_en_r};
      REG_FRAME_WIN:  cfg_prdata = {{(CFG_DW-WINDOW_W){1'b0}}, frame_win_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg_pready     = 1'b1;
  assign barrier_enable = barrier_en_r;
  assign frame_window   = frame_win_r;

endmodule

// ===== src/rhs_ctrl.sv =====
// ---------------------------------------------------------------------------
// rhs_ctrl
// Request sequencer: accepts one request, scans the table for access and
// frame-advance requests, waits for the output register, commits the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rhs_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rhs_pkg::IN_USER_W-1:0]  in_tuser,   // [1:0] req_type
  input  rhs_pkg::stat_t                 stat,
  output rhs_pkg::cmd_t                  cmd
);
  import rhs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       needs_scan;

  assign needs_scan = (in_tuser == REQ_ACCESS) || (in_tuser == REQ_ADVANCE);
  assign in_tready  = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = needs_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      // last entry is compared here
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_commit_free, clk, rst_n, cmd.commit |-> stat.out_free, "commit with output busy")
  `ASSERT_CLK(a_scan_end, clk, rst_n, (state_r == S_SCAN && stat.scan_last) |=> (state_r == S_DRAIN), "scan did not end")
  `ASSERT_CLK(a_one_item, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "second request taken while busy")
  `ASSERT_CLK(a_commit_idle, clk, rst_n, cmd.commit |=> (state_r == S_IDLE), "no return to idle after commit")

endmodule

// ===== src/rhs_dp.sv =====
// ---------------------------------------------------------------------------
// rhs_dp
// Scoreboard datapath: entry memory, valid bits, scan compare pipeline,
// hazard/barrier counters and the output register.
// ---------------------------------------------------------------------------
module rhs_dp #(
  parameter int ENTRIES      = rhs_pkg::ENTRIES_DEF,
  parameter int MAX_REPORTED = rhs_pkg::MAX_REPORTED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rhs_pkg::cmd_t                   cmd,
  output rhs_pkg::stat_t                  stat,
  input  logic [rhs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [rhs_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            barrier_enable,
  input  logic [rhs_pkg::WINDOW_W-1:0]    frame_window,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rhs_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rhs_pkg::*;

  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MW    = $clog2(MAX_REPORTED + 1);
  localparam int RW    = $clog2(ENTRIES + 1);
  localparam int ENT_W = FRAME_W + 1 + RES_W;

  // captured request
  logic [1:0]         req_r;
  logic [RES_W-1:0]   res_r;
  logic               rd_r, wr_r;
  logic [FRAME_W-1:0] frame_r;
  logic [STAGE_W-1:0] stages_r;

  // table
  logic [ENT_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENT_W-1:0]   rdata_r;
  logic               mem_we;

  // scan pipeline
  logic [AW-1:0]      addr_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;
  logic               ent_vld_r;

  // accumulators
  logic               hit_r;
  logic [MW-1:0]      mcnt_r;
  logic               free_found_r;
  logic [AW-1:0]      free_idx_r;
  logic [RW-1:0]      rem_r;

  // counters and output
  logic [TOTAL_W-1:0] hz_tot_r, hz_tot_nxt;
  logic [TOTAL_W-1:0] bar_tot_r, bar_tot_nxt;
  logic               out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // entry fields from memory
  logic [RES_W-1:0]   ent_res;
  logic               ent_wr;
  logic [FRAME_W-1:0] ent_frame;
  logic [FRAME_W-1:0] age;
  logic               conflict, too_old, do_free;

  logic               is_access, do_hz, do_bar, ovf;
  logic [MW+MATCH_W-1:0] mcnt_ext;
  logic [RW+REMOV_W-1:0] rem_ext;

  assign stat.scan_last = (addr_r == AW'(ENTRIES - 1));
  assign stat.out_free  = !out_vld_r || out_tready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_tuser;
      res_r    <= in_tdata[15:0];
      rd_r     <= in_tdata[16];
      wr_r     <= in_tdata[17];
      frame_r  <= in_tdata[49:18];
      stages_r <= in_tdata[57:50];
    end
  end

  // scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.scan) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  assign is_access = (req_r == REQ_ACCESS);
  assign mem_we    = cmd.commit && is_access && free_found_r;

  // entry memory, one read port registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[free_idx_r] <= {frame_r, wr_r, res_r};
    if (cmd.scan) rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx_r  <= addr_r;
      ent_vld_r <= valid_r[addr_r];
    end
  end

  // compare stage
  assign ent_res   = rdata_r[RES_W-1:0];
  assign ent_wr    = rdata_r[RES_W];
  assign ent_frame = rdata_r[ENT_W-1:RES_W+1];
  assign age       = frame_r - ent_frame;
  assign too_old   = age > {{(FRAME_W-WINDOW_W){1'b0}}, frame_window};
  assign conflict  = rd_vld_r && ent_vld_r && is_access && (ent_res == res_r) &&
                     ((ent_wr && (rd_r || wr_r)) || (!ent_wr && wr_r));
  assign do_free   = rd_vld_r && ent_vld_r && (req_r == REQ_ADVANCE) && too_old;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r        <= 1'b0;
      mcnt_r       <= '0;
      free_found_r <= 1'b0;
      rem_r        <= '0;
    end else begin
      if (conflict) begin
        hit_r <= 1'b1;
        if (mcnt_r != MW'(MAX_REPORTED)) mcnt_r <= mcnt_r + MW'(1);
      end
      // first free entry seen is the lowest
      if (rd_vld_r && !ent_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (do_free) rem_r <= rem_r + RW'(1);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && (req_r == REQ_CLEAR)) begin
      valid_r <= '0;
    end else begin
      if (do_free) valid_r[rd_idx_r] <= 1'b0;
      if (mem_we)  valid_r[free_idx_r] <= 1'b1;
    end
  end

  // counters and result
  assign do_hz  = is_access && hit_r;
  assign do_bar = do_hz && barrier_enable;
  assign ovf    = is_access && !free_found_r;

  assign mcnt_ext = {{MATCH_W{1'b0}}, mcnt_r};
  assign rem_ext  = {{REMOV_W{1'b0}}, rem_r};

  always_comb begin
    if (req_r == REQ_RESET_CNT) begin
      hz_tot_nxt  = '0;
      bar_tot_nxt = '0;
    end else begin
      hz_tot_nxt  = hz_tot_r + {{(TOTAL_W-1){1'b0}}, do_hz};
      bar_tot_nxt = bar_tot_r + {{(TOTAL_W-1){1'b0}}, do_bar};
    end
    out_data_nxt = {1'b0,
                    bar_tot_nxt,
                    hz_tot_nxt,
                    (req_r == REQ_ADVANCE) ? rem_ext[REMOV_W-1:0] : {REMOV_W{1'b0}},
                    ovf,
                    is_access ? mcnt_ext[MATCH_W-1:0] : {MATCH_W{1'b0}},
                    do_bar ? stages_r : {STAGE_W{1'b0}},
                    do_bar,
                    do_hz};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_tot_r  <= '0;
      bar_tot_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        hz_tot_r  <= hz_tot_nxt;
        bar_tot_r <= bar_tot_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
